### rtl/dmrt_pkg.sv
// Shared types and constants of the damage rectangle merge tracker.
`default_nettype none

package dmrt_pkg;

  localparam int MAX_RECTS = 16;
  localparam int IDX_W     = $clog2(MAX_RECTS);
  localparam int CNT_W     = 5;
  localparam int CFG_W     = 14;
  localparam int POS_W     = 13;
  localparam int DIM_W     = 14;
  localparam int ENTRY_W   = 2 * POS_W + 2 * DIM_W;

  localparam logic [DIM_W-1:0] SCREEN_MAX      = DIM_W'(8192);
  localparam logic [CFG_W-1:0] WIDTH_RESET     = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET    = CFG_W'(480);

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_APPEND,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } entry_t;

endpackage

`default_nettype wire

### rtl/dmrt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module dmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/damage_rect_merge_tracker_unit.sv
// Damage rectangle merge tracker: top level with control, clipping and merge datapath.
//
//   channel  | ports                                              | direction
//   ---------+----------------------------------------------------+----------
//   command  | start, busy, mode_i, rect_*_i, entry_index_i       | in; busy out
//   result   | done_o, full_flag_o, rect_count_o, repaint_pulse_o, | out
//            | out_x_o, out_y_o, out_w_o, out_h_o, out_valid_o     |
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i                    | in
//
// A command beat is taken at an edge with start high and busy low. Mark full,
// clear, whole-screen adds, rejected adds and reads at or above the count
// deliver their result beat after the execute state, a read of a stored entry
// after the read state, and any other add after the scan state (skipped when
// the list is empty) and the append state. The scan reads one stored entry
// per cycle from the rectangle RAM, which has separate read and write ports;
// this sets the add time. busy falls in the cycle that carries done_o, so a new
// command can be taken there. Reset clears the full flag and the count; the RAM
// needs no clearing because only entries below the count are ever read. The result
// receiver cannot stall: each result beat is valid for exactly one cycle.
`default_nettype none

module damage_rect_merge_tracker_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_idx_i,
  input  wire logic        [dmrt_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [1:0]                    mode_i,
  input  wire logic signed [15:0]                   rect_x_i,
  input  wire logic signed [15:0]                   rect_y_i,
  input  wire logic signed [15:0]                   rect_w_i,
  input  wire logic signed [15:0]                   rect_h_i,
  input  wire logic        [3:0]                    entry_index_i,
  output logic                                      done_o,
  output logic                                      full_flag_o,
  output logic             [dmrt_pkg::CNT_W-1:0]    rect_count_o,
  output logic                                      repaint_pulse_o,
  output logic             [dmrt_pkg::POS_W-1:0]    out_x_o,
  output logic             [dmrt_pkg::POS_W-1:0]    out_y_o,
  output logic             [dmrt_pkg::DIM_W-1:0]    out_w_o,
  output logic             [dmrt_pkg::DIM_W-1:0]    out_h_o,
  output logic                                      out_valid_o
);

  import dmrt_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= WIDTH_RESET;
      scr_h_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i;
        default:           scr_w_q <= scr_w_q;
      endcase
    end
  end

  // Screen size saturated to 1..8192.
  function automatic logic [DIM_W-1:0] dim_sat(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > CFG_W'(SCREEN_MAX)) begin
      r = SCREEN_MAX;
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // Clips one axis: start and end after clipping, and whether anything is left.
  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] lo;
    logic [DIM_W-1:0] hi;
  } span_t;

  function automatic span_t clip_axis(input logic signed [15:0] p,
                                      input logic signed [15:0] len,
                                      input logic [DIM_W-1:0]   lim);
    logic signed [17:0] ps, ls, es, ss, lo_s, hi_s;
    span_t r;
    ps   = {{2{p[15]}}, p};
    ls   = {{2{len[15]}}, len};
    es   = ps + ls;
    ss   = $signed({4'b0000, lim});
    lo_s = (ps < 0) ? 18'sd0 : ps;
    hi_s = (es > ss) ? ss : es;
    r.ok = (ls > 0) && (lo_s < ss) && (hi_s > lo_s);
    r.lo = lo_s[POS_W-1:0];
    r.hi = hi_s[DIM_W-1:0];
    return r;
  endfunction

  // Control and working registers.
  state_e            state_q, state_d;
  mode_e             mode_q;
  logic signed [15:0] in_x_q, in_y_q, in_w_q, in_h_q;
  logic [IDX_W-1:0]  in_idx_q;
  logic              full_q, full_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0]  wp_q, wp_d;
  logic [POS_W-1:0]  run_x0_q, run_x0_d, run_y0_q, run_y0_d;
  logic [DIM_W-1:0]  run_x1_q, run_x1_d, run_y1_q, run_y1_d;
  logic              done_q, done_d, pulse_q, pulse_d, ov_q, ov_d;
  entry_t            oent_q, oent_d;

  // RAM port.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  dmrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RECTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Clipping of the pending add against the current screen.
  span_t            span_x, span_y;
  logic [DIM_W-1:0] scr_w, scr_h;
  logic             add_ok, add_whole;

  assign scr_w     = dim_sat(scr_w_q);
  assign scr_h     = dim_sat(scr_h_q);
  assign span_x    = clip_axis(in_x_q, in_w_q, scr_w);
  assign span_y    = clip_axis(in_y_q, in_h_q, scr_h);
  assign add_ok    = !full_q && span_x.ok && span_y.ok;
  assign add_whole = (span_x.lo == '0) && (span_y.lo == '0) &&
                     (span_x.hi == scr_w) && (span_y.hi == scr_h);

  // Overlap test of the running rectangle against the entry read this cycle.
  logic [DIM_W:0]   ent_x1, ent_y1;
  logic             hit;
  logic [POS_W-1:0] mrg_x0, mrg_y0;
  logic [DIM_W-1:0] mrg_x1, mrg_y1;
  logic             scan_last;

  assign ent_x1 = {2'b00, ram_rdata.x} + {1'b0, ram_rdata.w};
  assign ent_y1 = {2'b00, ram_rdata.y} + {1'b0, ram_rdata.h};
  assign hit    = ({2'b00, run_x0_q} <= ent_x1) && ({1'b0, run_x1_q} >= {2'b00, ram_rdata.x}) &&
                  ({2'b00, run_y0_q} <= ent_y1) && ({1'b0, run_y1_q} >= {2'b00, ram_rdata.y});
  assign mrg_x0 = (run_x0_q < ram_rdata.x) ? run_x0_q : ram_rdata.x;
  assign mrg_y0 = (run_y0_q < ram_rdata.y) ? run_y0_q : ram_rdata.y;
  // Stored rectangles never reach past 8192, so the end fits the size width.
  assign mrg_x1 = (run_x1_q > ent_x1[DIM_W-1:0]) ? run_x1_q : ent_x1[DIM_W-1:0];
  assign mrg_y1 = (run_y1_q > ent_y1[DIM_W-1:0]) ? run_y1_q : ent_y1[DIM_W-1:0];
  assign scan_last = (CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (mode_q)
          MODE_ADD: begin
            if (!add_ok || add_whole) state_d = ST_IDLE;
            else if (count_q == '0)   state_d = ST_APPEND;
            else                      state_d = ST_SCAN;
          end
          MODE_READ: begin
            state_d = (CNT_W'(in_idx_q) < count_q) ? ST_READ : ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_APPEND;
      end
      ST_APPEND: state_d = ST_IDLE;
      ST_READ:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM access and result.
  always_comb begin
    full_d     = full_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    wp_d       = wp_q;
    run_x0_d   = run_x0_q;
    run_y0_d   = run_y0_q;
    run_x1_d   = run_x1_q;
    run_y1_d   = run_y1_q;
    done_d     = 1'b0;
    pulse_d    = 1'b0;
    ov_d       = 1'b0;
    oent_d     = '0;
    ram_we     = 1'b0;
    ram_waddr  = wp_q[IDX_W-1:0];
    ram_raddr  = '0;
    ram_wdata  = ram_rdata;

    unique case (state_q)
      ST_EXEC: begin
        unique case (mode_q)
          MODE_ADD: begin
            if (!add_ok) begin
              done_d = 1'b1;
            end else if (add_whole) begin
              full_d  = 1'b1;
              count_d = '0;
              pulse_d = 1'b1;
              done_d  = 1'b1;
            end else begin
              run_x0_d   = span_x.lo;
              run_y0_d   = span_y.lo;
              run_x1_d   = span_x.hi;
              run_y1_d   = span_y.hi;
              scan_idx_d = '0;
              wp_d       = '0;
              ram_raddr  = '0;
            end
          end
          MODE_FULL: begin
            full_d  = 1'b1;
            count_d = '0;
            pulse_d = 1'b1;
            done_d  = 1'b1;
          end
          MODE_CLEAR: begin
            full_d  = 1'b0;
            count_d = '0;
            done_d  = 1'b1;
          end
          MODE_READ: begin
            ram_raddr = in_idx_q;
            done_d    = !(CNT_W'(in_idx_q) < count_q);
          end
          default: done_d = 1'b1;
        endcase
      end
      ST_SCAN: begin
        // Merged entries drop out; the rest move down to the write pointer.
        ram_raddr  = scan_idx_q + IDX_W'(1);
        scan_idx_d = scan_idx_q + IDX_W'(1);
        if (hit) begin
          run_x0_d = mrg_x0;
          run_y0_d = mrg_y0;
          run_x1_d = mrg_x1;
          run_y1_d = mrg_y1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          wp_d      = wp_q + CNT_W'(1);
        end
      end
      ST_APPEND: begin
        pulse_d = 1'b1;
        done_d  = 1'b1;
        if (wp_q >= CNT_W'(MAX_RECTS)) begin
          full_d  = 1'b1;
          count_d = '0;
        end else begin
          ram_we      = 1'b1;
          ram_wdata.x = run_x0_q;
          ram_wdata.y = run_y0_q;
          ram_wdata.w = run_x1_q - DIM_W'(run_x0_q);
          ram_wdata.h = run_y1_q - DIM_W'(run_y0_q);
          count_d     = wp_q + CNT_W'(1);
        end
      end
      ST_READ: begin
        oent_d = ram_rdata;
        ov_d   = 1'b1;
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      full_q  <= 1'b0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      mode_q   <= mode_e'(mode_i);
      in_x_q   <= rect_x_i;
      in_y_q   <= rect_y_i;
      in_w_q   <= rect_w_i;
      in_h_q   <= rect_h_i;
      in_idx_q <= IDX_W'(entry_index_i);
    end
    scan_idx_q <= scan_idx_d;
    wp_q       <= wp_d;
    run_x0_q   <= run_x0_d;
    run_y0_q   <= run_y0_d;
    run_x1_q   <= run_x1_d;
    run_y1_q   <= run_y1_d;
    pulse_q    <= pulse_d;
    ov_q       <= ov_d;
    oent_q     <= oent_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign full_flag_o     = full_q;
  assign rect_count_o    = count_q;
  assign repaint_pulse_o = pulse_q;
  assign out_x_o         = oent_q.x;
  assign out_y_o         = oent_q.y;
  assign out_w_o         = oent_q.w;
  assign out_h_o         = oent_q.h;
  assign out_valid_o     = ov_q;

  // A set full flag always comes with an empty list.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (count_q == '0))
    else $error("full flag set with stored rectangles");

  // The list never grows past its capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECTS))
    else $error("rectangle count above capacity");

  // Compaction never writes ahead of the entry being scanned.
  a_wp_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (wp_q <= CNT_W'(scan_idx_q)))
    else $error("write pointer passed scan index");

  // One result beat per command: a result is never followed by another at once.
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("back to back result beats");

  // A read result never requests a repaint.
  a_read_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !pulse_q)
    else $error("read result with repaint pulse");

endmodule

`default_nettype wire

### dv/damage_rect_merge_tracker_unit_test.sv
// Self-checking testbench of the damage rectangle merge tracker, with its own prediction.
`timescale 1ns / 1ps

module damage_rect_merge_tracker_unit_test;
  import dmrt_pkg::*;

  // Run length and safety limits. The slowest command is an add that scans a full list, and
  // even with the sender's idle gaps the limit leaves a wide margin.
  localparam int RUN_CMDS    = 2000;
  localparam int PHASE_CMDS  = 250;
  localparam int SETTLE_CYC  = MAX_RECTS + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 50;

  // What the stimulus backlog holds: a command beat, a register write, or a pause in which
  // the sender waits until every pending result beat has come back.
  typedef enum logic [1:0] {
    KIND_CMD,
    KIND_CFG,
    KIND_DRAIN
  } backlog_kind_e;

  typedef struct {
    backlog_kind_e      kind;
    mode_e              mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [3:0]         idx;
    cfg_idx_e           cfg_sel;
    logic [CFG_W-1:0]   cfg_data;
    int                 idle_pct;
  } backlog_item_t;

  // One tracker status beat, as the result ports carry it.
  typedef struct {
    logic             full;
    logic [CNT_W-1:0] count;
    logic             repaint;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic             valid;
  } tracker_status_t;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } damage_box_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = 1'b0;
  logic [CFG_W-1:0]    cfg_data_i    = '0;
  logic                start         = 1'b0;
  logic                busy;
  logic [1:0]          mode_i        = MODE_ADD;
  logic signed [15:0]  rect_x_i      = '0;
  logic signed [15:0]  rect_y_i      = '0;
  logic signed [15:0]  rect_w_i      = '0;
  logic signed [15:0]  rect_h_i      = '0;
  logic [3:0]          entry_index_i = '0;
  logic                done_o;
  logic                full_flag_o;
  logic [CNT_W-1:0]    rect_count_o;
  logic                repaint_pulse_o;
  logic [POS_W-1:0]    out_x_o;
  logic [POS_W-1:0]    out_y_o;
  logic [DIM_W-1:0]    out_w_o;
  logic [DIM_W-1:0]    out_h_o;
  logic                out_valid_o;

  damage_rect_merge_tracker_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_w_i        (rect_w_i),
    .rect_h_i        (rect_h_i),
    .entry_index_i   (entry_index_i),
    .done_o          (done_o),
    .full_flag_o     (full_flag_o),
    .rect_count_o    (rect_count_o),
    .repaint_pulse_o (repaint_pulse_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_w_o         (out_w_o),
    .out_h_o         (out_h_o),
    .out_valid_o     (out_valid_o)
  );

  backlog_item_t   cmd_backlog_q[$];
  tracker_status_t status_beats_q[$];
  int              mismatch_cnt = 0;
  int              cmd_total    = 0;
  bit              cmd_taken    = 1'b0;

  // Screen size as the stimulus generator sees it, so random rectangles land near the screen.
  int gen_sw = 640;
  int gen_sh = 480;

  // Shadow copy of the tracker: registers, full flag, count and the rectangle list.
  logic [CFG_W-1:0] scr_w_reg = WIDTH_RESET;
  logic [CFG_W-1:0] scr_h_reg = HEIGHT_RESET;
  logic             mdl_full  = 1'b0;
  int               mdl_count = 0;
  damage_box_t      mdl_rects [MAX_RECTS];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A register value of zero acts as one pixel, and anything above the largest screen
  // acts as the largest screen.
  function automatic int clamp_screen(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > SCREEN_MAX) return int'(SCREEN_MAX);
    return int'(v);
  endfunction

  // Applies one command beat to the shadow tracker and returns the status beat it must cause.
  function automatic tracker_status_t track_damage(mode_e m, logic signed [15:0] ax,
                                                   logic signed [15:0] ay,
                                                   logic signed [15:0] aw,
                                                   logic signed [15:0] ah,
                                                   logic [3:0] idx);
    tracker_status_t s;
    int sw, sh, x, y, w, h, i, k;
    int ax1, ay1, bx1, by1, nx0, ny0, nx1, ny1;
    bit usable;
    s = '{default: '0};
    case (m)
      MODE_ADD: begin
        sw = clamp_screen(scr_w_reg);
        sh = clamp_screen(scr_h_reg);
        x = ax;
        y = ay;
        w = aw;
        h = ah;
        // A full screen or an empty size ends the add at once; clipping can still leave
        // nothing on screen, which is ignored the same way.
        usable = !mdl_full && w > 0 && h > 0;
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (y < 0) begin
          h += y;
          y = 0;
        end
        if (x >= sw || y >= sh) usable = 1'b0;
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        if (w <= 0 || h <= 0) usable = 1'b0;
        if (usable) begin
          s.repaint = 1'b1;
          if (x == 0 && y == 0 && w == sw && h == sh) begin
            mdl_full  = 1'b1;
            mdl_count = 0;
          end else begin
            // One forward pass: a merged entry is removed and the list closes up, so the
            // same slot is looked at again, but earlier slots are never revisited.
            i = 0;
            while (i < mdl_count) begin
              ax1 = x + w;
              ay1 = y + h;
              bx1 = mdl_rects[i].x + mdl_rects[i].w;
              by1 = mdl_rects[i].y + mdl_rects[i].h;
              if (x <= bx1 && ax1 >= mdl_rects[i].x && y <= by1 && ay1 >= mdl_rects[i].y) begin
                nx0 = (x < mdl_rects[i].x) ? x : mdl_rects[i].x;
                ny0 = (y < mdl_rects[i].y) ? y : mdl_rects[i].y;
                nx1 = (ax1 > bx1) ? ax1 : bx1;
                ny1 = (ay1 > by1) ? ay1 : by1;
                x = nx0;
                y = ny0;
                w = nx1 - nx0;
                h = ny1 - ny0;
                for (k = i; k + 1 < mdl_count; k++) mdl_rects[k] = mdl_rects[k + 1];
                mdl_count--;
              end else begin
                i++;
              end
            end
            if (mdl_count >= MAX_RECTS) begin
              mdl_full  = 1'b1;
              mdl_count = 0;
            end else begin
              mdl_rects[mdl_count] = '{x: x, y: y, w: w, h: h};
              mdl_count++;
            end
          end
        end
      end
      MODE_FULL: begin
        mdl_full  = 1'b1;
        mdl_count = 0;
        s.repaint = 1'b1;
      end
      MODE_CLEAR: begin
        mdl_full  = 1'b0;
        mdl_count = 0;
      end
      default: begin
        if (int'(idx) < mdl_count) begin
          s.ox    = POS_W'(mdl_rects[idx].x);
          s.oy    = POS_W'(mdl_rects[idx].y);
          s.ow    = DIM_W'(mdl_rects[idx].w);
          s.oh    = DIM_W'(mdl_rects[idx].h);
          s.valid = 1'b1;
        end
      end
    endcase
    s.full  = mdl_full;
    s.count = CNT_W'(mdl_count);
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // A backlog entry with every field at a defined starting value.
  function automatic backlog_item_t blank_item();
    backlog_item_t it;
    it.kind     = KIND_CMD;
    it.mode     = MODE_ADD;
    it.x        = '0;
    it.y        = '0;
    it.w        = '0;
    it.h        = '0;
    it.idx      = '0;
    it.cfg_sel  = CFG_SCREEN_WIDTH;
    it.cfg_data = '0;
    it.idle_pct = 0;
    return it;
  endfunction

  // The sender idles at a rate that depends on how far the run has come: moderate, then
  // heavy, then not at all for the last third.
  task automatic push_cmd(mode_e m, int x, int y, int w, int h, int idx);
    backlog_item_t it;
    it = blank_item();
    it.kind     = KIND_CMD;
    it.mode     = m;
    it.x        = 16'(x);
    it.y        = 16'(y);
    it.w        = 16'(w);
    it.h        = 16'(h);
    it.idx      = 4'(idx);
    it.idle_pct = (cmd_total < RUN_CMDS / 3) ? 38 : (cmd_total < 2 * RUN_CMDS / 3) ? 51 : 0;
    cmd_backlog_q.push_back(it);
    cmd_total++;
  endtask

  task automatic push_cfg(cfg_idx_e sel, int data);
    backlog_item_t it;
    it = blank_item();
    it.kind     = KIND_CFG;
    it.cfg_sel  = sel;
    it.cfg_data = CFG_W'(data);
    cmd_backlog_q.push_back(it);
    if (sel == CFG_SCREEN_WIDTH) gen_sw = clamp_screen(CFG_W'(data));
    else gen_sh = clamp_screen(CFG_W'(data));
  endtask

  task automatic push_drain();
    backlog_item_t it;
    it = blank_item();
    it.kind = KIND_DRAIN;
    cmd_backlog_q.push_back(it);
  endtask

  // A well-formed damage sequence: clear, then a run of adds. Most adds sit in separate cells
  // of a 5 x 4 grid with a gap of at least two pixels, so they neither touch nor merge and a
  // long run overflows the list; a few free rectangles fall across cells and cause merges.
  task automatic push_burst();
    int order [20];
    int n, j, t, cw, ch, cx, cy, rx, ry, rw, rh;
    push_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom_range(15));
    n  = $urandom_range(1) ? $urandom_range(14, 20) : $urandom_range(1, 13);
    cw = gen_sw / 5;
    ch = gen_sh / 4;
    for (j = 0; j < 20; j++) order[j] = j;
    for (j = 19; j > 0; j--) begin
      t        = $urandom_range(j);
      cx       = order[j];
      order[j] = order[t];
      order[t] = cx;
    end
    for (j = 0; j < n; j++) begin
      if (cw < 3 || ch < 3 || $urandom_range(7) == 0) begin
        rx = int'($urandom_range(0, gen_sw + gen_sw / 4 + 2)) - (gen_sw / 8 + 1);
        ry = int'($urandom_range(0, gen_sh + gen_sh / 4 + 2)) - (gen_sh / 8 + 1);
        rw = $urandom_range(1, gen_sw / 2 + 2);
        rh = $urandom_range(1, gen_sh / 2 + 2);
      end else begin
        cx = order[j] % 5;
        cy = order[j] / 5;
        rx = cx * cw + 1 + $urandom_range(0, (cw - 3) / 2);
        ry = cy * ch + 1 + $urandom_range(0, (ch - 3) / 2);
        rw = $urandom_range(1, cx * cw + cw - 1 - rx);
        rh = $urandom_range(1, cy * ch + ch - 1 - ry);
      end
      push_cmd(MODE_ADD, rx, ry, rw, rh, $urandom_range(15));
      if ($urandom_range(3) == 0)
        push_cmd(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom_range(15));
    end
    if ($urandom_range(5) == 0) begin
      push_cmd(MODE_FULL, $urandom, $urandom, $urandom, $urandom, $urandom_range(15));
      push_cmd(MODE_ADD, $urandom_range(0, 15), $urandom_range(0, 15), 4, 4, 0);
    end
    push_cmd(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom_range(15));
    push_cmd(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom_range(15));
  endtask

  // Noise: either every field fully random, or an add of small size near the screen with
  // empty and negative sizes mixed in.
  task automatic push_noise();
    if ($urandom_range(1))
      push_cmd(mode_e'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
               $urandom_range(15));
    else
      push_cmd(MODE_ADD, int'($urandom_range(0, gen_sw + 20)) - 10,
               int'($urandom_range(0, gen_sh + 20)) - 10, int'($urandom_range(0, 40)) - 8,
               int'($urandom_range(0, 40)) - 8, $urandom_range(15));
  endtask

  // Driver: inputs change on the falling edge. A command stays on the port until the rising
  // edge that takes it; register writes and pauses wait until no status beat is pending.
  always @(negedge clk_i) begin
    logic          next_start;
    logic          next_we;
    backlog_item_t head;
    next_start = start;
    next_we    = 1'b0;
    if (rst_ni && (!start || cmd_taken)) begin
      next_start = 1'b0;
      if (cmd_backlog_q.size() > 0) begin
        head = cmd_backlog_q[0];
        case (head.kind)
          KIND_CMD: begin
            if (int'($urandom_range(99)) >= head.idle_pct) begin
              mode_i        <= head.mode;
              rect_x_i      <= head.x;
              rect_y_i      <= head.y;
              rect_w_i      <= head.w;
              rect_h_i      <= head.h;
              entry_index_i <= head.idx;
              next_start    = 1'b1;
              void'(cmd_backlog_q.pop_front());
            end
          end
          KIND_CFG: begin
            if (status_beats_q.size() == 0 && !busy) begin
              cfg_idx_i  <= head.cfg_sel;
              cfg_data_i <= head.cfg_data;
              next_we    = 1'b1;
              void'(cmd_backlog_q.pop_front());
            end
          end
          default: begin
            if (status_beats_q.size() == 0 && !busy) void'(cmd_backlog_q.pop_front());
          end
        endcase
      end
    end
    start    <= next_start;
    cfg_we_i <= next_we;
  end

  // Monitor: samples at the rising edge. A register write updates the shadow registers, a
  // result beat is checked against the oldest pending status, and a command beat taken at
  // this edge is run through the prediction.
  always @(posedge clk_i) begin
    tracker_status_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCREEN_WIDTH) scr_w_reg = cfg_data_i;
        else scr_h_reg = cfg_data_i;
      end
      if (done_o) begin
        if (status_beats_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, count", rect_count_o, 0);
        end else begin
          want = status_beats_q.pop_front();
          if (full_flag_o !== want.full) report_mismatch("full_flag", full_flag_o, want.full);
          if (rect_count_o !== want.count)
            report_mismatch("rect_count", rect_count_o, want.count);
          if (repaint_pulse_o !== want.repaint)
            report_mismatch("repaint_pulse", repaint_pulse_o, want.repaint);
          if (out_x_o !== want.ox) report_mismatch("out_x", out_x_o, want.ox);
          if (out_y_o !== want.oy) report_mismatch("out_y", out_y_o, want.oy);
          if (out_w_o !== want.ow) report_mismatch("out_w", out_w_o, want.ow);
          if (out_h_o !== want.oh) report_mismatch("out_h", out_h_o, want.oh);
          if (out_valid_o !== want.valid)
            report_mismatch("out_valid", out_valid_o, want.valid);
        end
      end
      cmd_taken = start && !busy;
      if (cmd_taken)
        status_beats_q.push_back(track_damage(mode_e'(mode_i), rect_x_i, rect_y_i, rect_w_i,
                                              rect_h_i, entry_index_i));
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus plan: eight screen settings, extremes and out-of-range values among them, each
  // followed by a stretch of random sequences. The first setting also gets the directed part.
  initial begin
    int scr_ws [8];
    int scr_hs [8];
    int ph;
    int phase_end;
    scr_ws = '{640, 8192, 1, 0, 16383, 100, 0, 8191};
    scr_hs = '{480, 8192, 1, 16383, 0, 60, 0, 3};
    scr_ws[6] = $urandom_range(15, 8192);
    scr_hs[6] = $urandom_range(12, 8192);
    for (ph = 0; ph < 8; ph++) begin
      push_cfg(CFG_SCREEN_WIDTH, scr_ws[ph]);
      push_cfg(CFG_SCREEN_HEIGHT, scr_hs[ph]);
      if (ph == 0) begin
        // A read of an empty list, then a touching pair that merges and a separate box.
        push_cmd(MODE_READ, 0, 0, 0, 0, 0);
        push_cmd(MODE_ADD, 10, 10, 20, 20, 0);
        push_cmd(MODE_ADD, 30, 10, 5, 5, 0);
        push_cmd(MODE_ADD, 200, 200, 10, 10, 0);
        push_cmd(MODE_READ, 0, 0, 0, 0, 0);
        push_cmd(MODE_READ, 0, 0, 0, 0, 1);
        push_cmd(MODE_READ, 0, 0, 0, 0, 15);
        // Empty sizes, off-screen corners and clipping from every side.
        push_cmd(MODE_ADD, 50, 50, 0, 10, 0);
        push_cmd(MODE_ADD, 50, 50, 10, -32768, 0);
        push_cmd(MODE_ADD, 640, 0, 10, 10, 0);
        push_cmd(MODE_ADD, -32768, 0, 32767, 10, 0);
        push_cmd(MODE_ADD, -5, -5, 20, 20, 0);
        push_cmd(MODE_ADD, 32767, 32767, 32767, 32767, 0);
        push_cmd(MODE_ADD, 630, 470, 100, 100, 0);
        push_cmd(MODE_READ, 0, 0, 0, 0, 2);
        // A whole-screen add sets the full flag; adds are then ignored until a clear.
        push_cmd(MODE_ADD, 0, 0, 640, 480, 0);
        push_cmd(MODE_ADD, 5, 5, 5, 5, 0);
        push_cmd(MODE_READ, 0, 0, 0, 0, 0);
        push_cmd(MODE_FULL, -1, -1, -1, -1, 15);
        push_cmd(MODE_CLEAR, 0, 0, 0, 0, 0);
        push_cmd(MODE_ADD, -100, -100, 32767, 32767, 0);
        push_cmd(MODE_CLEAR, 32767, -32768, 32767, -32768, 15);
        push_cmd(MODE_ADD, 639, 479, 1, 1, 0);
        push_cmd(MODE_READ, 0, 0, 0, 0, 0);
        push_drain();
      end
      phase_end = cmd_total + PHASE_CMDS;
      while (cmd_total < phase_end) begin
        if ($urandom_range(3) == 0) push_noise();
        else push_burst();
        if ($urandom_range(39) == 0) push_drain();
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog_q.size() > 0 || start) @(posedge clk_i);
    while (status_beats_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dmrt_pkg.sv
rtl/dmrt_ram.sv
rtl/damage_rect_merge_tracker_unit.sv
dv/damage_rect_merge_tracker_unit_test.sv
